>>> hw/rtl/btpl_pkg.sv
// shared types and codes for the binary trie prefix lookup
`timescale 1ns / 1ps
package btpl_pkg;

   localparam int unsigned ADDR_BITS = 16;
   localparam int unsigned HOP_BITS  = 8;
   localparam int unsigned LEN_W     = $clog2(ADDR_BITS + 1);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_LOOKUP = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_HOP   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      func_type                 func;
      logic [ADDR_BITS-1:0]     prefix_bits;
      logic [4:0]               prefix_len;
      logic signed [HOP_BITS:0] next_hop;
      logic [ADDR_BITS-1:0]     lookup_addr;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [HOP_BITS-1:0] found_hop;
   } rsp_type;

endpackage

>>> hw/rtl/btpl_front.sv
// request decode and two-entry command queue toward the walk engine
`timescale 1ns / 1ps
module btpl_front #(
   parameter int unsigned ADDR_BITS = 16,
   parameter int unsigned HOP_BITS  = 8,
   localparam int unsigned LEN_W    = $clog2(ADDR_BITS + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  btpl_pkg::func_type        func,
   input  logic [ADDR_BITS-1:0]      prefix_bits,
   input  logic [4:0]                prefix_len,
   input  logic signed [HOP_BITS:0]  next_hop,
   input  logic [ADDR_BITS-1:0]      lookup_addr,
   output logic                      full,
   output logic                      cmd_valid,
   input  logic                      cmd_pop,
   output btpl_pkg::func_type        cmd_func,
   output logic [ADDR_BITS-1:0]      cmd_path,
   output logic [LEN_W-1:0]          cmd_len,
   output logic signed [HOP_BITS:0]  cmd_hop,
   output logic                      cmd_bad_hop
);
   typedef struct packed {
      btpl_pkg::func_type       func;
      logic [ADDR_BITS-1:0]     path;
      logic [LEN_W-1:0]         len;
      logic signed [HOP_BITS:0] hop;
      logic                     bad_hop;
   } cmd_type;

   cmd_type     q_ff [2];
   cmd_type     entry_in;
   logic        wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0] len_c;

   always_comb begin
      // overlong prefixes are cut to a full address
      if ({1'b0, prefix_len} > 6'(ADDR_BITS)) len_c = LEN_W'(ADDR_BITS);
      else len_c = LEN_W'(prefix_len);
      entry_in.func    = func;
      entry_in.path    = (func == btpl_pkg::FUNC_LOOKUP) ? lookup_addr : prefix_bits;
      entry_in.len     = (func == btpl_pkg::FUNC_LOOKUP) ? LEN_W'(ADDR_BITS) : len_c;
      entry_in.hop     = next_hop;
      entry_in.bad_hop = next_hop < -1;
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wr_ff] <= entry_in;
   end

   assign full        = cnt_ff == 2'd2;
   assign cmd_valid   = cnt_ff != 2'd0;
   assign cmd_func    = q_ff[rd_ff].func;
   assign cmd_path    = q_ff[rd_ff].path;
   assign cmd_len     = q_ff[rd_ff].len;
   assign cmd_hop     = q_ff[rd_ff].hop;
   assign cmd_bad_hop = q_ff[rd_ff].bad_hop;

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !cmd_valid |-> !cmd_pop) else $error("queue underflow");
   a_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("bad queue count");
`endif
endmodule

>>> hw/rtl/btpl_walk.sv
// trie walk engine: one node memory read per level
`timescale 1ns / 1ps
module btpl_walk #(
   parameter int unsigned ADDR_BITS  = 16,
   parameter int unsigned NODE_COUNT = 1024,
   parameter int unsigned HOP_BITS   = 8,
   localparam int unsigned LEN_W     = $clog2(ADDR_BITS + 1),
   localparam int unsigned IDX_W     = $clog2(NODE_COUNT),
   localparam int unsigned FREE_W    = $clog2(NODE_COUNT + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   input  btpl_pkg::func_type       cmd_func,
   input  logic [ADDR_BITS-1:0]     cmd_path,
   input  logic [LEN_W-1:0]         cmd_len,
   input  logic signed [HOP_BITS:0] cmd_hop,
   input  logic                     cmd_bad_hop,
   output logic                     idle,
   output logic                     rsp_strobe,
   output btpl_pkg::status_type     rsp_status,
   output logic [HOP_BITS-1:0]      rsp_found_hop
);
   typedef enum logic [1:0] {S_IDLE, S_STEP, S_READ} state_type;

   logic [2*IDX_W-1:0]      links_mem [NODE_COUNT];
   logic signed [HOP_BITS:0] hops_mem [NODE_COUNT];

   state_type                state_ff;
   logic [IDX_W-1:0]         root_l_ff, root_r_ff;
   logic signed [HOP_BITS:0] root_hop_ff;
   logic [FREE_W-1:0]        free_ff;
   btpl_pkg::func_type       func_ff;
   logic [ADDR_BITS-1:0]     path_ff;
   logic [LEN_W-1:0]         len_ff, lvl_ff;
   logic signed [HOP_BITS:0] hop_ff;
   logic [IDX_W-1:0]         cur_ff;
   logic [2*IDX_W-1:0]       rd_links_ff;
   logic signed [HOP_BITS:0] rd_hop_ff;
   logic [HOP_BITS-1:0]      best_ff;
   logic                     strobe_ff;
   btpl_pkg::status_type     status_ff;
   logic [HOP_BITS-1:0]      found_ff;

   logic                     side;
   logic [IDX_W-1:0]         child, new_idx;
   logic [2*IDX_W-1:0]       cur_links;

   always_comb begin
      side      = path_ff[ADDR_BITS-1];
      cur_links = (cur_ff == '0) ? {root_r_ff, root_l_ff} : rd_links_ff;
      child     = side ? cur_links[2*IDX_W-1:IDX_W] : cur_links[IDX_W-1:0];
      new_idx   = free_ff[IDX_W-1:0];
   end

   assign cmd_pop = (state_ff == S_IDLE) && cmd_valid;
   assign idle    = (state_ff == S_IDLE) && !cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         root_l_ff   <= '0;
         root_r_ff   <= '0;
         root_hop_ff <= '0;
         free_ff     <= FREE_W'(1);
         strobe_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  func_ff <= cmd_func;
                  path_ff <= cmd_path;
                  len_ff  <= cmd_len;
                  hop_ff  <= cmd_hop;
                  lvl_ff  <= '0;
                  cur_ff  <= '0;
                  best_ff <= (root_hop_ff > 0) ? root_hop_ff[HOP_BITS-1:0] : '0;
                  if (cmd_func == btpl_pkg::FUNC_NOP ||
                      (cmd_func == btpl_pkg::FUNC_INSERT && cmd_bad_hop)) begin
                     strobe_ff <= 1'b1;
                     status_ff <= (cmd_func == btpl_pkg::FUNC_NOP) ?
                                  btpl_pkg::ST_OK : btpl_pkg::ST_BAD_HOP;
                     found_ff  <= '0;
                  end else begin
                     state_ff <= S_STEP;
                  end
               end
            end
            S_STEP: begin
               if (lvl_ff == len_ff) begin
                  // reached target node (or lookup ran out of bits)
                  strobe_ff <= 1'b1;
                  status_ff <= btpl_pkg::ST_OK;
                  found_ff  <= (func_ff == btpl_pkg::FUNC_LOOKUP) ? best_ff : '0;
                  if (func_ff != btpl_pkg::FUNC_LOOKUP) begin
                     if (cur_ff == '0) begin
                        root_hop_ff <= (func_ff == btpl_pkg::FUNC_INSERT) ? hop_ff : '0;
                     end else begin
                        hops_mem[cur_ff] <= (func_ff == btpl_pkg::FUNC_INSERT) ?
                                            hop_ff : '0;
                     end
                  end
                  state_ff <= S_IDLE;
               end else if (child != '0) begin
                  cur_ff      <= child;
                  rd_links_ff <= links_mem[child];
                  rd_hop_ff   <= hops_mem[child];
                  path_ff     <= path_ff << 1;
                  lvl_ff      <= lvl_ff + 1'b1;
                  state_ff    <= S_READ;
               end else if (func_ff == btpl_pkg::FUNC_INSERT) begin
                  if (free_ff >= FREE_W'(NODE_COUNT)) begin
                     strobe_ff <= 1'b1;
                     status_ff <= btpl_pkg::ST_FULL;
                     found_ff  <= '0;
                     state_ff  <= S_IDLE;
                  end else begin
                     // allocate a fresh node and link it in
                     links_mem[new_idx] <= '0;
                     hops_mem[new_idx]  <= '0;
                     if (cur_ff == '0) begin
                        if (side) root_r_ff <= new_idx;
                        else root_l_ff <= new_idx;
                     end else begin
                        links_mem[cur_ff] <= side ? {new_idx, cur_links[IDX_W-1:0]} :
                                             {cur_links[2*IDX_W-1:IDX_W], new_idx};
                     end
                     free_ff     <= free_ff + 1'b1;
                     cur_ff      <= new_idx;
                     rd_links_ff <= '0;
                     path_ff     <= path_ff << 1;
                     lvl_ff      <= lvl_ff + 1'b1;
                     state_ff    <= S_STEP;
                  end
               end else begin
                  strobe_ff <= 1'b1;
                  status_ff <= (func_ff == btpl_pkg::FUNC_DELETE) ?
                               btpl_pkg::ST_NOT_FOUND : btpl_pkg::ST_OK;
                  found_ff  <= (func_ff == btpl_pkg::FUNC_LOOKUP) ? best_ff : '0;
                  state_ff  <= S_IDLE;
               end
            end
            S_READ: begin
               if (rd_hop_ff > 0) best_ff <= rd_hop_ff[HOP_BITS-1:0];
               else if (rd_hop_ff == -1) best_ff <= '0;
               state_ff <= S_STEP;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_found_hop = found_ff;

`ifndef SYNTHESIS
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_W'(NODE_COUNT) && free_ff != '0) else $error("free index out of range");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> state_ff == S_STEP || rsp_strobe) else $error("pop without start");
   a_level: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> lvl_ff <= len_ff) else $error("walk past length");
`endif
endmodule

>>> hw/rtl/binary_trie_prefix_lookup.sv
// top level of the binary trie longest prefix lookup
`timescale 1ns / 1ps
// a rejected or unused request answers without a walk; a full walk visits every
// trie level through a step state and, for an existing node, a read state on the node memory.
// throughput: one request per walk, a two-entry queue lets requests land meanwhile.
// reset clears the root and the allocator; pool nodes are written when allocated.
// results appear for one cycle on rsp_strobe and cannot be stalled.
module binary_trie_prefix_lookup #(
   parameter int unsigned NODE_COUNT = 1024
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  btpl_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output btpl_pkg::rsp_type           rsp_data
);
   logic                                 full, cmd_valid, cmd_pop, cmd_bad_hop, idle;
   btpl_pkg::func_type                   cmd_func;
   btpl_pkg::status_type                 status;
   logic [btpl_pkg::HOP_BITS-1:0]        found_hop;
   logic [btpl_pkg::ADDR_BITS-1:0]       cmd_path;
   logic [btpl_pkg::LEN_W-1:0]           cmd_len;
   logic signed [btpl_pkg::HOP_BITS:0]   cmd_hop;

   assign busy = full;

   btpl_front #(.ADDR_BITS(btpl_pkg::ADDR_BITS), .HOP_BITS(btpl_pkg::HOP_BITS)) u_front (
      .clock, .reset, .push(start && !full),
      .func(req_data.func), .prefix_bits(req_data.prefix_bits),
      .prefix_len(req_data.prefix_len), .next_hop(req_data.next_hop),
      .lookup_addr(req_data.lookup_addr), .full, .cmd_valid, .cmd_pop, .cmd_func,
      .cmd_path, .cmd_len, .cmd_hop, .cmd_bad_hop);

   btpl_walk #(.ADDR_BITS(btpl_pkg::ADDR_BITS), .NODE_COUNT(NODE_COUNT),
               .HOP_BITS(btpl_pkg::HOP_BITS)) u_walk (
      .clock, .reset, .cmd_valid, .cmd_pop, .cmd_func, .cmd_path, .cmd_len,
      .cmd_hop, .cmd_bad_hop, .idle, .rsp_strobe, .rsp_status(status),
      .rsp_found_hop(found_hop));

   assign rsp_data = {status, found_hop};

`ifndef SYNTHESIS
   a_idle_no_strobe: assert property (@(posedge clock) disable iff (reset)
      $past(idle) && idle |-> !rsp_strobe) else $error("result while idle");
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != btpl_pkg::ST_OK |-> rsp_data.found_hop == '0)
      else $error("hop on error");
   a_busy_queue: assert property (@(posedge clock) disable iff (reset)
      busy |-> !idle) else $error("busy while idle");
`endif
endmodule

>>> tb/binary_trie_prefix_lookup_tb.sv
// self-checking testbench for the binary trie prefix lookup
`timescale 1ns / 1ps
module binary_trie_prefix_lookup_tb;

   localparam int N_NODES    = 1024;
   localparam int N_RANDOM   = 1330;
   localparam int WDOG_LIMIT = 5000;

   typedef struct {
      btpl_pkg::func_type   func;
      logic [15:0]          bits;
      logic [4:0]           len;
      logic signed [8:0]    hop;
      logic [15:0]          addr;
      bit                   typed;
      btpl_pkg::status_type st;
      logic [7:0]           fhop;
   } stim_type;

   typedef struct {
      btpl_pkg::status_type st;
      logic [7:0]           fhop;
   } reply_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   btpl_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   btpl_pkg::rsp_type rsp_data;

   // trie mirror: index 0 is the root, children of 0 mean null
   int          kids [N_NODES][2];
   int          hops [N_NODES];
   int          free_idx;
   reply_type   pending [$];
   int          n_acc = 0;
   int          n_bad = 0;
   int          idle_cnt = 0;
   bit          cur_typed = 0;
   reply_type   cur_reply;
   logic [15:0] bases [6];

   binary_trie_prefix_lookup uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic reply_type trie_apply(logic [1:0] f, logic [15:0] b, logic [4:0] l,
                                            logic signed [8:0] h, logic [15:0] a);
      reply_type r;
      int        cur, nxt, len, best, i;
      r.st = btpl_pkg::ST_OK;
      r.fhop = '0;
      len = (l > 16) ? 16 : l;
      cur = 0;
      case (f)
         btpl_pkg::FUNC_INSERT: begin
            if (h < -1) begin
               r.st = btpl_pkg::ST_BAD_HOP;
            end else begin
               for (i = 0; i < len; i++) begin
                  nxt = kids[cur][b[15-i]];
                  if (nxt == 0) begin
                     if (free_idx >= N_NODES) begin
                        r.st = btpl_pkg::ST_FULL;
                        break;
                     end
                     nxt = free_idx++;
                     kids[nxt][0] = 0;
                     kids[nxt][1] = 0;
                     hops[nxt] = 0;
                     kids[cur][b[15-i]] = nxt;
                  end
                  cur = nxt;
               end
               if (r.st == btpl_pkg::ST_OK) hops[cur] = h;
            end
         end
         btpl_pkg::FUNC_DELETE: begin
            for (i = 0; i < len; i++) begin
               nxt = kids[cur][b[15-i]];
               if (nxt == 0) begin
                  r.st = btpl_pkg::ST_NOT_FOUND;
                  break;
               end
               cur = nxt;
            end
            if (r.st == btpl_pkg::ST_OK) hops[cur] = 0;
         end
         btpl_pkg::FUNC_LOOKUP: begin
            best = (hops[0] > 0) ? hops[0] : 0;
            for (i = 0; i < 16; i++) begin
               cur = kids[cur][a[15-i]];
               if (cur == 0) break;
               if (hops[cur] > 0) best = hops[cur];
               else if (hops[cur] == -1) best = 0;
            end
            r.fhop = best[7:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   // results first, then the request taken at this edge
   always @(posedge clock) begin
      reply_type exp_r, pred;
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending.size() == 0) begin
               n_bad++;
               if (n_bad <= 10) $display("unexpected result status=%0d hop=%0d",
                                         rsp_data.status, rsp_data.found_hop);
            end else begin
               exp_r = pending.pop_front();
               if (rsp_data.status !== exp_r.st || rsp_data.found_hop !== exp_r.fhop) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("mismatch: exp status=%0d hop=%0d got status=%0d hop=%0d",
                              exp_r.st, exp_r.fhop, rsp_data.status, rsp_data.found_hop);
               end
            end
         end
         if (start && !busy) begin
            pred = trie_apply(req_data.func, req_data.prefix_bits, req_data.prefix_len,
                              req_data.next_hop, req_data.lookup_addr);
            pending.push_back(cur_typed ? cur_reply : pred);
            n_acc <= n_acc + 1;
         end
         if ((start && !busy) || rsp_strobe) idle_cnt <= 0;
         else idle_cnt <= idle_cnt + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cnt >= WDOG_LIMIT) begin
         $display("[binary_trie_prefix_lookup] ERROR");
         $finish;
      end
   end

   task automatic send(stim_type s, bit may_idle);
      int prev;
      if (may_idle && $urandom_range(0, 99) < 12) begin
         start = 0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      prev = n_acc;
      start = 1;
      req_data.func = s.func;
      req_data.prefix_bits = s.bits;
      req_data.prefix_len = s.len;
      req_data.next_hop = s.hop;
      req_data.lookup_addr = s.addr;
      cur_typed = s.typed;
      cur_reply.st = s.st;
      cur_reply.fhop = s.fhop;
      do @(negedge clock); while (n_acc == prev);
   endtask

   function automatic stim_type mk(btpl_pkg::func_type f, logic [15:0] b, logic [4:0] l,
                                   logic signed [8:0] h, logic [15:0] a, bit t,
                                   btpl_pkg::status_type st, logic [7:0] fh);
      stim_type s;
      s.func = f; s.bits = b; s.len = l; s.hop = h; s.addr = a;
      s.typed = t; s.st = st; s.fhop = fh;
      return s;
   endfunction

   initial begin
      stim_type dir [$];
      stim_type s;
      int       k, r, pick;
      for (k = 0; k < N_NODES; k++) begin
         kids[k][0] = 0; kids[k][1] = 0; hops[k] = 0;
      end
      free_idx = 1;
      for (k = 0; k < 6; k++) bases[k] = 16'($urandom_range(0, 65535));

      // directed rows: typed expectations where they are obvious
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hffff, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 16'h1234, 4, -2, 0, 1, btpl_pkg::ST_BAD_HOP, 0));
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 16'hffff, 16, -256, 0, 1, btpl_pkg::ST_BAD_HOP, 0));
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 0, 0, 255, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'h0000, 1, btpl_pkg::ST_OK, 255));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hffff, 1, btpl_pkg::ST_OK, 255));
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 16'hffff, 16, 7, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hffff, 1, btpl_pkg::ST_OK, 7));
      // overlong length acts as a full-width prefix
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 16'h0000, 31, 1, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'h0000, 1, btpl_pkg::ST_OK, 1));
      dir.push_back(mk(btpl_pkg::FUNC_DELETE, 16'h8000, 5, 0, 0, 1, btpl_pkg::ST_NOT_FOUND, 0));
      dir.push_back(mk(btpl_pkg::FUNC_DELETE, 0, 0, 0, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_NOP, 16'hffff, 31, 255, 16'hffff, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 16'hf000, 4, -1, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hffff, 1, btpl_pkg::ST_OK, 7));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hf000, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_DELETE, 16'hffff, 16, 0, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hffff, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_DELETE, 16'hffff, 16, 0, 0, 1, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_INSERT, 16'hf000, 3, 128, 0, 0, btpl_pkg::ST_OK, 0));
      dir.push_back(mk(btpl_pkg::FUNC_LOOKUP, 0, 0, 0, 16'hefff, 0, btpl_pkg::ST_OK, 0));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      foreach (dir[k]) send(dir[k], 1);

      for (k = 0; k < N_RANDOM; k++) begin
         if (k == 800) begin
            start = 0;
            while (pending.size() != 0) @(negedge clock);
         end
         pick = $urandom_range(0, 5);
         r = $urandom_range(0, 99);
         s.typed = 0; s.st = btpl_pkg::ST_OK; s.fhop = 0;
         s.func = (r < 35) ? btpl_pkg::FUNC_INSERT :
                  (r < 47) ? btpl_pkg::FUNC_DELETE :
                  (r < 96) ? btpl_pkg::FUNC_LOOKUP : btpl_pkg::FUNC_NOP;
         // late phase: long random prefixes drain the node pool
         if (k > 1050 && $urandom_range(0, 1)) begin
            s.bits = 16'($urandom_range(0, 65535));
            s.len = 16;
         end else begin
            s.bits = bases[pick] ^ 16'($urandom_range(0, 15));
            s.len = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(1, 10));
         end
         r = $urandom_range(0, 9);
         s.hop = (r == 0) ? -9'sd1 : (r == 1) ? 9'sd0 :
                 (r == 2) ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 255));
         s.addr = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                              : bases[pick] ^ 16'($urandom_range(0, 255));
         send(s, !(k >= 300 && k < 600));
      end
      start = 0;

      while (pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (n_bad == 0) $display("[binary_trie_prefix_lookup] OK");
      else $display("[binary_trie_prefix_lookup] ERROR");
      $finish;
   end
endmodule
